[src/mspl_pkg.sv]
package mspl_pkg;

	// Motor count and field widths
	localparam int NUM_MOTORS = 3;
	localparam int MOTOR_W    = 2;
	localparam int POWER_W    = 8;
	localparam int ENC_W      = 32;
	localparam int TIME_W     = 32;

	// Configuration register widths
	localparam int DEAD_ZONE_W = 7;
	localparam int TIMEOUT_W   = 16;
	localparam int MOVE_W      = 20;

	// Stream word widths (padded to whole bytes)
	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 8;

	// APB address and data widths
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	// Register indexes
	localparam logic [1:0] REG_DEAD_ZONE = 2'd0;
	localparam logic [1:0] REG_TIMEOUT   = 2'd1;
	localparam logic [1:0] REG_MOVE      = 2'd2;

	// Register reset values
	localparam logic [DEAD_ZONE_W-1:0] DEAD_ZONE_RST = 7'd10;
	localparam logic [TIMEOUT_W-1:0]   TIMEOUT_RST   = 16'd150;
	localparam logic [MOVE_W-1:0]      MOVE_RST      = 20'd1000;

endpackage

[src/motor_stall_power_limiter_unit.sv]
// Per-motor stall guard on requested motor power. A word is taken every clock
// cycle when the output side keeps up; each accepted word passes through one
// input register and one result register, with the stall decision between
// them. The per-motor arm flag and mark (time, encoder count)
// are updated at the same edge that loads the result, so a following word for
// the same motor sees the new mark. Power below dead_zone passes and disarms the
// motor; a timeout with no encoder move beyond significant_move forces power to
// zero and raises tuser. Motor index beyond the motor count passes unchanged.
module motor_stall_power_limiter_unit
	import mspl_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// input stream
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// fields from bit 0: motor_index[2], wanted_power[8], encoder_count[32],
	// now_ms[32], zero pad[6]
	input  logic [IN_DATA_W-1:0]   s_tdata,
	// output stream
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// fields from bit 0: power_out[8]
	output logic [OUT_DATA_W-1:0]  m_tdata,
	// fields from bit 0: stalled[1]
	output logic                   m_tuser,
	// configuration port
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [ADDR_W-1:0]      paddr,
	input  logic [DATA_W-1:0]      pwdata,
	output logic [DATA_W-1:0]      prdata,
	output logic                   pready
);

	// Configuration registers
	logic [DEAD_ZONE_W-1:0] dead_zone_q;
	logic [TIMEOUT_W-1:0]   timeout_q;
	logic [MOVE_W-1:0]      move_q;

	// Per-motor state
	logic [NUM_MOTORS-1:0]  armed_q;
	logic [TIME_W-1:0]      mark_time_q [NUM_MOTORS];
	logic [ENC_W-1:0]       mark_enc_q  [NUM_MOTORS];

	// Input stage
	logic                   valid_s1;
	logic [MOTOR_W-1:0]     motor_s1;
	logic [POWER_W-1:0]     power_s1;
	logic [ENC_W-1:0]       enc_s1;
	logic [TIME_W-1:0]      now_s1;

	// Result stage
	logic                   valid_s2;
	logic [POWER_W-1:0]     power_s2;
	logic                   stalled_s2;

	// Decision logic
	logic                   advance;
	logic                   in_range;
	logic [NUM_MOTORS-1:0]  hit;
	logic                   cur_armed;
	logic [TIME_W-1:0]      cur_time;
	logic [ENC_W-1:0]       cur_enc;
	logic [POWER_W-1:0]     mag;
	logic                   below;
	logic signed [ENC_W:0]  enc_diff;
	logic [ENC_W:0]         enc_dist;
	logic                   moved;
	logic [TIME_W-1:0]      elapsed;
	logic                   timed_out;
	logic                   do_arm;
	logic                   do_mark;
	logic                   do_stall;
	logic                   cfg_wr;

	// APB access
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_zone_q <= DEAD_ZONE_RST;
			timeout_q   <= TIMEOUT_RST;
			move_q      <= MOVE_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_DEAD_ZONE: dead_zone_q <= pwdata[DEAD_ZONE_W-1:0];
				REG_TIMEOUT:   timeout_q   <= pwdata[TIMEOUT_W-1:0];
				REG_MOVE:      move_q      <= pwdata[MOVE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_DEAD_ZONE: prdata = {{(DATA_W-DEAD_ZONE_W){1'b0}}, dead_zone_q};
			REG_TIMEOUT:   prdata = {{(DATA_W-TIMEOUT_W){1'b0}}, timeout_q};
			REG_MOVE:      prdata = {{(DATA_W-MOVE_W){1'b0}}, move_q};
			default:       prdata = '0;
		endcase
	end

	// Handshake: the result stage frees up when empty or being taken
	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Capture the input word
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			motor_s1 <= s_tdata[1:0];
			power_s1 <= s_tdata[9:2];
			enc_s1   <= s_tdata[41:10];
			now_s1   <= s_tdata[73:42];
		end
	end

	// Select the addressed motor's state
	always_comb begin
		cur_armed = 1'b0;
		cur_time  = '0;
		cur_enc   = '0;
		for (int i = 0; i < NUM_MOTORS; i++) begin
			hit[i] = (motor_s1 == MOTOR_W'(i));
			if (hit[i]) begin
				cur_armed = armed_q[i];
				cur_time  = mark_time_q[i];
				cur_enc   = mark_enc_q[i];
			end
		end
		in_range = |hit;
	end

	// Power magnitude, encoder distance and elapsed time
	always_comb begin
		mag       = power_s1[POWER_W-1] ? POWER_W'(-power_s1) : power_s1;
		below     = mag < {1'b0, dead_zone_q};
		enc_diff  = $signed({enc_s1[ENC_W-1], enc_s1}) - $signed({cur_enc[ENC_W-1], cur_enc});
		enc_dist  = enc_diff[ENC_W] ? (ENC_W+1)'(-enc_diff) : enc_diff;
		moved     = enc_dist > {{(ENC_W+1-MOVE_W){1'b0}}, move_q};
		elapsed   = now_s1 - cur_time;
		timed_out = elapsed > {{(TIME_W-TIMEOUT_W){1'b0}}, timeout_q};
		do_arm    = in_range && !below && !cur_armed;
		do_mark   = in_range && !below && cur_armed && moved;
		do_stall  = in_range && !below && cur_armed && !moved && timed_out;
	end

	// Update per-motor state as the word moves to the result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= '0;
			for (int i = 0; i < NUM_MOTORS; i++) begin
				mark_time_q[i] <= '0;
				mark_enc_q[i]  <= '0;
			end
		end else if (valid_s1 && advance) begin
			for (int i = 0; i < NUM_MOTORS; i++) begin
				if (hit[i]) begin
					if (below) begin
						armed_q[i] <= 1'b0;
					end else if (do_arm) begin
						armed_q[i] <= 1'b1;
					end
					if (do_arm || do_mark) begin
						mark_time_q[i] <= now_s1;
						mark_enc_q[i]  <= enc_s1;
					end
				end
			end
		end
	end

	// Result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			power_s2   <= do_stall ? '0 : power_s1;
			stalled_s2 <= do_stall;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = power_s2;
	assign m_tuser  = stalled_s2;

	// A stalled word always carries zero power
	a_stall_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("stalled word with nonzero power");

	// Input stage is never overwritten while it holds a word that cannot move
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |-> !s_tready)
		else $error("input accepted while input stage blocked");

	// A powered request on an unarmed motor arms it
	a_arm: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance && do_arm |=> armed_q[$past(motor_s1)])
		else $error("motor not armed after arming step");

	// A request below the dead zone disarms the motor
	a_disarm: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance && in_range && below |=> !armed_q[$past(motor_s1)])
		else $error("motor still armed after unpowered request");

	// Stalling only happens on an armed motor
	a_stall_armed: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && do_stall |-> cur_armed && in_range)
		else $error("stall on unarmed motor");

endmodule

[test/tb.sv]
module tb;
	import mspl_pkg::*;

	typedef struct {
		logic [MOTOR_W-1:0]        motor;
		logic signed [POWER_W-1:0] power;
		logic signed [ENC_W-1:0]   enc;
		logic [TIME_W-1:0]         now;
	} power_req_t;

	typedef struct {
		logic [POWER_W-1:0] power;
		logic               stalled;
	} allowed_power_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	// fields from bit 0: motor_index[2], wanted_power[8], encoder_count[32],
	// now_ms[32], zero pad[6]
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// fields from bit 0: power_out[8]
	logic [OUT_DATA_W-1:0] m_tdata;
	// fields from bit 0: stalled[1]
	logic                  m_tuser;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [ADDR_W-1:0]     paddr = '0;
	logic [DATA_W-1:0]     pwdata = '0;
	logic [DATA_W-1:0]     prdata;
	logic                  pready;

	motor_stall_power_limiter_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Limiter copy of the block: settings and per-motor arm state
	logic [DEAD_ZONE_W-1:0]  dead_zone_r = DEAD_ZONE_RST;
	logic [TIMEOUT_W-1:0]    timeout_r   = TIMEOUT_RST;
	logic [MOVE_W-1:0]       move_r      = MOVE_RST;
	logic                    is_armed   [NUM_MOTORS];
	logic [TIME_W-1:0]       mark_ms    [NUM_MOTORS];
	logic signed [ENC_W-1:0] mark_ticks [NUM_MOTORS];

	// Per-motor trajectory used to build plausible request sequences
	bit [TIME_W-1:0] run_ms    [NUM_MOTORS];
	bit [ENC_W-1:0]  run_ticks [NUM_MOTORS];

	power_req_t     request_q[$];
	allowed_power_t allowed_q[$];
	power_req_t     shown;
	bit             holding = 1'b0;
	bit             calm = 1'b0;
	int             errors = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		errors++;
	endtask

	// Work out the allowed power for one request and advance the motor state
	function automatic allowed_power_t guard_power(input power_req_t r);
		allowed_power_t res;
		int             m;
		int             mag;
		longint         enc_dist;
		logic [TIME_W-1:0] elapsed;
		res.power   = r.power;
		res.stalled = 1'b0;
		m = r.motor;
		if (m < NUM_MOTORS) begin
			mag = (r.power < 0) ? -int'(r.power) : int'(r.power);
			if (mag < dead_zone_r) begin
				is_armed[m] = 1'b0;
			end else if (!is_armed[m]) begin
				is_armed[m]   = 1'b1;
				mark_ms[m]    = r.now;
				mark_ticks[m] = r.enc;
			end else begin
				enc_dist = longint'(r.enc) - longint'(mark_ticks[m]);
				if (enc_dist < 0)
					enc_dist = -enc_dist;
				if (enc_dist > longint'(move_r)) begin
					mark_ms[m]    = r.now;
					mark_ticks[m] = r.enc;
				end else begin
					elapsed = r.now - mark_ms[m];
					if (elapsed > timeout_r) begin
						res.power   = '0;
						res.stalled = 1'b1;
					end
				end
			end
		end
		return res;
	endfunction

	task automatic push_req(input int m, input int p, input logic [31:0] e,
			input logic [31:0] t);
		power_req_t r;
		r.motor = MOTOR_W'(m);
		r.power = POWER_W'(p);
		r.enc   = e;
		r.now   = t;
		request_q.push_back(r);
	endtask

	// Build one request that mostly follows a motor's trajectory
	task automatic queue_random_req();
		power_req_t  r;
		int unsigned sel;
		int unsigned mag;
		int unsigned step;
		int          m;
		sel = $urandom_range(0, 19);
		r.motor = (sel == 0) ? MOTOR_W'(3) : MOTOR_W'($urandom_range(0, NUM_MOTORS - 1));
		// pick the power around the dead zone
		sel = $urandom_range(0, 9);
		if (sel < 2)
			mag = (dead_zone_r == 0) ? 0 : $urandom_range(0, dead_zone_r - 1);
		else if (sel == 2)
			mag = dead_zone_r;
		else
			mag = $urandom_range(dead_zone_r, 128);
		if (mag == 128 || (mag != 0 && $urandom_range(0, 1) == 1))
			r.power = POWER_W'(-int'(mag));
		else
			r.power = POWER_W'(mag);
		if (sel == 9)
			r.power = POWER_W'($urandom);
		if (r.motor >= NUM_MOTORS) begin
			r.enc = $urandom;
			r.now = $urandom;
		end else begin
			m = r.motor;
			// advance time: mostly short, sometimes right at or past the timeout
			sel = $urandom_range(0, 9);
			case (sel)
				6: step = timeout_r;
				7: step = timeout_r + 1;
				8: step = $urandom_range(timeout_r, timeout_r * 2 + 2);
				9: step = $urandom;
				default: step = $urandom_range(0, timeout_r / 3 + 1);
			endcase
			run_ms[m] += step;
			// move the encoder: mostly small, sometimes at or past the threshold
			sel = $urandom_range(0, 9);
			case (sel)
				6: step = move_r;
				7: step = move_r + 1;
				8: step = $urandom_range(move_r, move_r * 4 + 4);
				9: step = $urandom;
				default: step = $urandom_range(0, move_r / 2);
			endcase
			if ($urandom_range(0, 1) == 1)
				run_ticks[m] -= step;
			else
				run_ticks[m] += step;
			r.enc = run_ticks[m];
			r.now = run_ms[m];
		end
		request_q.push_back(r);
	endtask

	// Write one register, then read it back in the following transfer
	task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_DEAD_ZONE: dead_zone_r = val[DEAD_ZONE_W-1:0];
			REG_TIMEOUT:   timeout_r   = val[TIMEOUT_W-1:0];
			REG_MOVE:      move_r      = val[MOVE_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== val)
			report_mismatch($sformatf("register %0d reads %0h, wrote %0h", idx, prdata, val));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_limits(input int unsigned dz, input int unsigned tmo,
			input int unsigned mv);
		write_reg(REG_DEAD_ZONE, dz);
		write_reg(REG_TIMEOUT, tmo);
		write_reg(REG_MOVE, mv);
	endtask

	// Wait until every request is taken and every result is back
	task automatic drain();
		while (request_q.size() != 0 || holding || allowed_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Input side: predict on each accepted word, then load the next one
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				allowed_q.push_back(guard_power(shown));
			if (!s_tvalid || s_tready) begin
				if (request_q.size() != 0 && (calm || $urandom_range(0, 99) >= 29)) begin
					shown = request_q.pop_front();
					s_tdata  <= {6'b0, shown.now, shown.enc, shown.power, shown.motor};
					s_tvalid <= 1'b1;
					holding = 1'b1;
				end else begin
					s_tvalid <= 1'b0;
					holding = 1'b0;
				end
			end
		end
	end

	// Output side: check each accepted word against the oldest prediction
	always @(posedge clk) begin
		allowed_power_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (allowed_q.size() == 0) begin
					report_mismatch($sformatf("unexpected word power %0h stalled %0b",
						m_tdata, m_tuser));
				end else begin
					want = allowed_q.pop_front();
					if (m_tdata !== want.power)
						report_mismatch($sformatf("power_out %0h, expected %0h",
							m_tdata, want.power));
					if (m_tuser !== want.stalled)
						report_mismatch($sformatf("stalled %0b, expected %0b",
							m_tuser, want.stalled));
				end
			end
			m_tready <= calm || $urandom_range(0, 99) >= 29;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: dead zone edges, arming, marks, timeout edges, wraps, bad index
		push_req(0, 5, 0, 0);
		push_req(0, 10, 100, 1000);
		push_req(0, 50, 1100, 1150);
		push_req(0, 50, 1100, 1151);
		push_req(0, -128, 2101, 5000);
		push_req(0, 127, 1100, 5100);
		push_req(0, -9, 1100, 5200);
		push_req(1, -128, 32'h7FFF_FFFF, 32'hFFFF_FFF0);
		push_req(1, 100, 32'h8000_0000, 32'hFFFF_FFF0);
		push_req(1, 100, 32'h8000_0000, 32'h0000_0080);
		push_req(1, 100, 32'h8000_0000, 32'h0000_0087);
		push_req(3, -128, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_req(3, 127, 0, 0);
		push_req(2, 0, 0, 0);
		push_req(2, 11, -1000, 10);
		push_req(2, -11, 0, 161);
		push_req(2, -1, 0, 170);
		push_req(2, 20, 32'h8000_0000, 32'hFFFF_FFFF);
		push_req(2, 20, 32'h7FFF_FFFF, 32'h0000_0000);
		drain();

		set_limits(DEAD_ZONE_RST, TIMEOUT_RST, MOVE_RST);
		repeat (150) queue_random_req();
		drain();

		set_limits(0, 0, 0);
		repeat (80) queue_random_req();
		drain();

		set_limits(127, 65535, 1048575);
		repeat (60) queue_random_req();
		drain();

		// Run one phase with both sides always ready
		calm = 1'b1;
		set_limits($urandom_range(0, 40), $urandom_range(1, 2000), $urandom_range(0, 5000));
		repeat (150) queue_random_req();
		drain();
		calm = 1'b0;

		set_limits($urandom_range(0, 127), $urandom_range(0, 65535), $urandom_range(0, 1048575));
		repeat (150) queue_random_req();
		drain();

		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
